/* hdl/b64o_pkg.sv */
// ----------------------------------------------------------------------------
// b64o_pkg: shared types and constants for the offset Base64 encoder
// Holds the alphabet lookup, the padding character and the group hand-over type.
// ----------------------------------------------------------------------------
`default_nettype none

package b64o_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned SEXTET_W    = 6;
   localparam int unsigned GROUP_BYTES = 3;
   localparam int unsigned GROUP_CHARS = 4;
   localparam int unsigned TRIPLE_W    = BYTE_W * GROUP_BYTES;
   localparam int unsigned COUNT_W     = $clog2(GROUP_CHARS + 1);

   localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;   // '='

   // number of trailing characters replaced by padding
   typedef logic [1:0] pad_count_type;

   // one completed (or final, partial) group, handed from packer to serialiser
   typedef struct packed {
      logic [TRIPLE_W-1:0] triple;
      pad_count_type       pad_count;
      logic                last;
   } group_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [BYTE_W-1:0] b64o_char(input logic [SEXTET_W-1:0] sextet);
      logic [BYTE_W-1:0] code;
      priority if (sextet < 6'd26) begin
         code = 8'h41 + {2'b00, sextet};
      end else if (sextet < 6'd52) begin
         code = 8'h61 + {2'b00, sextet - 6'd26};
      end else if (sextet < 6'd62) begin
         code = 8'h30 + {2'b00, sextet - 6'd52};
      end else if (sextet == 6'd62) begin
         code = 8'h2B;
      end else begin
         code = 8'h2F;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* hdl/b64o_packer.sv */
// ----------------------------------------------------------------------------
// b64o_packer: input register and byte-group assembly
// Registers each request, adds the offset and gathers bytes into groups of three.
// ----------------------------------------------------------------------------
`default_nettype none

module b64o_packer
   import b64o_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_final_byte,
   input  wire logic              csr_write_enable,
   input  wire logic [BYTE_W-1:0] csr_write_data,
   output logic                   grp_valid,
   input  wire logic              grp_ready,
   output group_type              grp
);

   typedef enum logic [1:0] {
      POS_EMPTY,
      POS_ONE,
      POS_TWO
   } position_type;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_final_ff;
   logic [BYTE_W-1:0] offset_ff;
   logic [2*BYTE_W-1:0] held_ff;
   position_type      pos_ff;

   logic [BYTE_W-1:0] shifted_byte;
   logic              closes;
   logic              take;

   assign shifted_byte = in_byte_ff + offset_ff;
   assign closes       = in_final_ff || (pos_ff == POS_TWO);
   assign take         = in_valid_ff && (!closes || grp_ready);
   assign req_stall    = in_valid_ff && !take;
   assign grp_valid    = in_valid_ff && closes;

   always_comb begin
      grp = '0;
      unique case (pos_ff)
         POS_ONE: begin
            grp.triple    = {held_ff[2*BYTE_W-1:BYTE_W], shifted_byte, {BYTE_W{1'b0}}};
            grp.pad_count = 2'd1;
            grp.last      = 1'b1;
         end
         POS_TWO: begin
            grp.triple    = {held_ff, shifted_byte};
            grp.pad_count = 2'd0;
            grp.last      = in_final_ff;
         end
         default: begin
            grp.triple    = {shifted_byte, {2*BYTE_W{1'b0}}};
            grp.pad_count = 2'd2;
            grp.last      = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         offset_ff   <= '0;
         held_ff     <= '0;
         pos_ff      <= POS_EMPTY;
      end else begin
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (take) begin
            priority if (closes) begin
               held_ff <= '0;
               pos_ff  <= POS_EMPTY;
            end else if (pos_ff == POS_ONE) begin
               held_ff[BYTE_W-1:0] <= shifted_byte;
               pos_ff              <= POS_TWO;
            end else begin
               held_ff <= {shifted_byte, {BYTE_W{1'b0}}};
               pos_ff  <= POS_ONE;
            end
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
   end

endmodule

`default_nettype wire

/* hdl/b64o_serializer.sv */
// ----------------------------------------------------------------------------
// b64o_serializer: character encoding and output shift register
// Turns one group into four characters, sent one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64o_serializer
   import b64o_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              grp_valid,
   output logic                   grp_ready,
   input  wire group_type         grp,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_code_char,
   output logic                   rsp_last_char
);

   logic [BYTE_W-1:0]  chars_ff [GROUP_CHARS];
   logic [COUNT_W-1:0] count_ff;
   logic               last_ff;

   logic [BYTE_W-1:0]  encoded [GROUP_CHARS];
   logic               pop;
   logic               load;

   assign rsp_valid     = (count_ff != '0);
   assign rsp_code_char = chars_ff[0];
   assign rsp_last_char = last_ff && (count_ff == COUNT_W'(1));
   assign pop           = rsp_valid && !rsp_stall;
   assign grp_ready     = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && pop);
   assign load          = grp_valid && grp_ready;

   // trailing characters become padding
   always_comb begin
      for (int k = 0; k < GROUP_CHARS; k++) begin
         if (k >= GROUP_CHARS - int'(grp.pad_count)) begin
            encoded[k] = PAD_CHAR;
         end else begin
            encoded[k] = b64o_char(grp.triple[TRIPLE_W-1-SEXTET_W*k -: SEXTET_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         if (load) begin
            count_ff <= COUNT_W'(GROUP_CHARS);
            last_ff  <= grp.last;
         end else if (pop) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < GROUP_CHARS; k++) begin
            chars_ff[k] <= encoded[k];
         end
      end else if (pop) begin
         for (int k = 0; k < GROUP_CHARS - 1; k++) begin
            chars_ff[k] <= chars_ff[k+1];
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/base64_encoder_with_byte_offset_core.sv */
// ----------------------------------------------------------------------------
// base64_encoder_with_byte_offset_core: Base64 encoder with byte offset
// Streams message bytes in, adds a configurable offset and emits Base64 text.
// ----------------------------------------------------------------------------
//
//   port group | direction | contents
//   -----------+-----------+-----------------------------------------------
//   req_*      | in        | one message byte, flag on the last byte
//   rsp_*      | out       | one ASCII character, flag on the last character
//   csr_*      | in        | byte offset write (enable + data)
//
// A request is held in the input register; a byte that completes a
// group (or carries the final flag) loads four characters into the output
// shift register once the serialiser is ready, and they leave one per cycle
// while the response is not stalled. Sustained rate is set by that output of
// one character per cycle, so every three bytes in give four characters out.
// Reset clears the group state, the offset and all valid flags.
// A stalled response holds; a completing request waits in the input register
// until the last character of the previous group is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_with_byte_offset_core
   import b64o_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_final_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_code_char,
   output logic                   rsp_last_char,
   input  wire logic              csr_write_enable,
   input  wire logic [BYTE_W-1:0] csr_write_data
);

   // hand-over between the packer and the serialiser
   logic      grp_valid;
   logic      grp_ready;
   group_type grp;

   // register the request, apply the offset, gather three bytes
   b64o_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .grp_valid        (grp_valid),
      .grp_ready        (grp_ready),
      .grp              (grp)
   );

   // encode the group, pad it, shift characters out
   b64o_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .grp_valid     (grp_valid),
      .grp_ready     (grp_ready),
      .grp           (grp),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_char (rsp_code_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

/* hdl/b64o_checker.sv */
// ----------------------------------------------------------------------------
// b64o_checker: port-level checks for the Base64 encoder
// Watches the top-level ports and flags broken output or stall behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module b64o_checker
   import b64o_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [BYTE_W-1:0] req_data_byte,
   input wire logic              req_final_byte,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_code_char,
   input wire logic              rsp_last_char
);

   // a stalled character stays on the port
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_char)
                                 && $stable(rsp_last_char))
      else $error("stalled response changed");

   // a stalled request stays on the port
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte)
                                 && $stable(req_final_byte))
      else $error("stalled request changed");

   // the last-character flag only comes with a valid character
   assert property (@(posedge clock) disable iff (reset)
      rsp_last_char |-> rsp_valid)
      else $error("last flag without valid response");

   // requests are only held back while characters are still pending
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   // leave reset idle
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind base64_encoder_with_byte_offset_core b64o_checker u_checker (.*);

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the offset Base64 encoder
// Streams byte messages through the core under random gaps and back-pressure,
// predicts every character from a behavioural copy of the group packer and
// compares each character leaving the core against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import b64o_pkg::*;

   localparam int IDLE_LIMIT  = 1000;   // cycles with no handshake before giving up
   localparam int LATENCY_PAD = 8;      // settle time after the last character

   // standard alphabet, first character in the top byte
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              last;
   } enc_char_type;

   // ------------------------------------------------------------------------
   // Ports; every input of the core is driven to a known value from time zero
   // ------------------------------------------------------------------------
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte    = '0;
   logic              req_final_byte   = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [BYTE_W-1:0] rsp_code_char;
   logic              rsp_last_char;
   logic              csr_write_enable = 1'b0;
   logic [BYTE_W-1:0] csr_write_data   = '0;

   base64_encoder_with_byte_offset_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_char    (rsp_code_char),
      .rsp_last_char    (rsp_last_char),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Encoder prediction: offset, open group bytes and how many are held
   // ------------------------------------------------------------------------
   logic [BYTE_W-1:0] enc_offset = '0;
   logic [15:0]       enc_held   = '0;
   logic [1:0]        enc_count  = '0;
   enc_char_type      expected_chars[$];

   int  error_count = 0;
   int  bytes_sent  = 0;
   bit  no_gaps     = 0;   // sender drives back to back
   bit  no_stalls   = 0;   // receiver always ready

   // Queue the four characters of one group; trailing positions become padding.
   task automatic push_group(input logic [23:0] triple, input int pad, input logic last);
      enc_char_type c;
      logic [5:0]   sextet;
      for (int k = 0; k < 4; k++) begin
         sextet = triple[18-6*k +: 6];
         c.code = ALPHABET[(63 - sextet)*8 +: 8];
         if (k >= 4 - pad) begin
            c.code = PAD_CHAR;
         end
         c.last = last && (k == 3);
         expected_chars.push_back(c);
      end
   endtask

   // Advance the packer by one accepted request.
   task automatic predict_byte(input logic [BYTE_W-1:0] raw, input logic fin);
      logic [BYTE_W-1:0] b;
      logic              closed;
      b      = raw + enc_offset;
      closed = 1'b1;
      case (enc_count)
         2'd1: begin
            enc_held[7:0] = b;
            if (fin) begin
               push_group({enc_held, 8'h00}, 1, 1'b1);   // two bytes held: one '='
            end else begin
               enc_count = 2'd2;
               closed    = 1'b0;
            end
         end
         2'd2: begin
            push_group({enc_held, b}, 0, fin);             // full group, no padding
         end
         default: begin
            enc_held = {b, 8'h00};
            if (fin) begin
               push_group({b, 16'h0000}, 2, 1'b1);       // single byte: "=="
            end else begin
               enc_count = 2'd1;
               closed    = 1'b0;
            end
         end
      endcase
      if (closed) begin
         enc_held  = '0;
         enc_count = '0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   // Present one request and hold it until the core takes it. Valid stays high
   // into the next request when no gap is drawn, so it is never dropped and
   // raised in the same step.
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(data, fin);
      bytes_sent++;
   endtask

   // Send a short literal, first byte in the most significant position.
   task automatic send_string(input logic [63:0] text, input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(text[(len-1-i)*8 +: 8], i == len - 1);
      end
   endtask

   task automatic send_random_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Drop valid, wait for every predicted character, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   task automatic set_offset(input logic [BYTE_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      enc_offset = value;
   endtask

   // ------------------------------------------------------------------------
   // Response side: check each taken character, then draw the next stall
   // ------------------------------------------------------------------------
   int           long_stall = 0;
   int           stall_roll;
   enc_char_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character expected none got %h last %b",
                     $time, rsp_code_char, rsp_last_char);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_code_char !== want.code) begin
               $display("%0t: code_char expected %h got %h",
                        $time, want.code, rsp_code_char);
               error_count++;
            end
            if (rsp_last_char !== want.last) begin
               $display("%0t: last_char expected %b got %b",
                        $time, want.last, rsp_last_char);
               error_count++;
            end
         end
      end
      // mostly ready, short stalls often, a long hold now and then
      stall_roll = $urandom_range(0, 99);
      if (no_stalls) begin
         rsp_stall <= 1'b0;
      end else if (long_stall > 0) begin
         long_stall <= long_stall - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_roll < 4) begin
         long_stall <= $urandom_range(8, 30);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= (stall_roll < 30);
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset offset of zero: classic vectors, all three padding cases, the
   // all-zero and all-ones bytes and the two highest alphabet entries.
   task automatic test_reset_offset();
      send_string(64'("Man"), 3);        // full group, no padding
      send_string(64'("Ma"), 2);         // two bytes held: one '='
      send_string(64'("M"), 1);          // single byte: "=="
      send_string(64'h000000, 3);
      send_string(64'hFFFFFF, 3);
      send_string(64'hFBEFBE, 3);        // every sextet 62
      send_string(64'h00, 1);
      send_string(64'hFFFF, 2);
      send_string(64'("Many h"), 6);     // message spanning two groups
   endtask

   // Offset extremes and a middle value; the wrap past 255 is exercised too.
   task automatic test_offset_extremes();
      set_offset(8'hFF);
      send_string(64'h000102, 3);
      send_string(64'h01, 1);
      set_offset(8'h01);
      send_string(64'hFFFEFF, 3);
      send_random_message(2);
      set_offset(8'h80);
      send_random_message(4);
   endtask

   // Hold the sender with two bytes of a group held until every character is out.
   task automatic test_pause_for_results();
      set_offset(BYTE_W'($urandom_range(0, 255)));
      for (int i = 0; i < 5; i++) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
      wait_idle();
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   // No gaps and no stalls: the core runs at its own rate.
   task automatic test_back_to_back();
      no_gaps   = 1;
      no_stalls = 1;
      repeat (3) send_random_message($urandom_range(4, 12));
      wait_idle();
      no_gaps   = 0;
      no_stalls = 0;
   endtask

   // Random messages under several offsets; mostly short, a few long.
   task automatic test_random_messages();
      int target;
      int phase;
      target = bytes_sent + 50;
      phase  = 0;
      while (bytes_sent < target) begin
         case (phase % 4)
            0:       set_offset(8'h00);
            1:       set_offset(8'hFF);
            default: set_offset(BYTE_W'($urandom_range(0, 255)));
         endcase
         repeat (3) begin
            if ($urandom_range(0, 99) < 80) begin
               send_random_message($urandom_range(1, 9));
            end else begin
               send_random_message($urandom_range(10, 30));
            end
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_offset();
      test_offset_extremes();
      test_pause_for_results();
      test_back_to_back();
      test_random_messages();

      // drain, then leave time for anything the core should not send
      wait_idle();
      repeat (LATENCY_PAD) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived", $time, expected_chars.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
